// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers used by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- src/dcs_pkg.sv -----
// ----------------------------------------------------------------------------
// dcs_pkg
// types and codes of the depth capture sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package dcs_pkg;

   typedef enum logic [2:0] {
      ST_IDLE    = 3'd0,
      ST_TRIG_B  = 3'd1,
      ST_TRIG_P  = 3'd2,
      ST_TRIG_R  = 3'd3,
      ST_TRIG_BP = 3'd4,
      ST_B_DONE  = 3'd5,
      ST_P_DONE  = 3'd6,
      ST_BP_DONE = 3'd7
   } dcs_state_type;

   typedef enum logic [1:0] {
      STS_OK      = 2'd0,
      STS_INVALID = 2'd1,
      STS_TIMEOUT = 2'd2,
      STS_IGNORED = 2'd3
   } dcs_status_type;

   localparam logic [4:0] OP_OPEN      = 5'd0;
   localparam logic [4:0] OP_PARA_LAST = 5'd6;
   localparam logic [4:0] OP_TRIG_R    = 5'd7;
   localparam logic [4:0] OP_TRIG_B    = 5'd8;
   localparam logic [4:0] OP_TRIG_P    = 5'd9;
   localparam logic [4:0] OP_SYNC      = 5'd10;
   localparam logic [4:0] OP_B_IRQ     = 5'd11;
   localparam logic [4:0] OP_P_IRQ     = 5'd12;
   localparam logic [4:0] OP_R_IRQ     = 5'd13;
   localparam logic [4:0] OP_REF_DEPTH = 5'd14;
   localparam logic [4:0] OP_REF_SHIFT = 5'd15;
   localparam logic [4:0] OP_TIMEOUT   = 5'd16;
   localparam logic [4:0] OP_TRIG_BP   = 5'd17;
   localparam logic [4:0] OP_NONE      = 5'd0;

   typedef struct packed {
      logic       is_event;
      logic [4:0] op;
   } dcs_item_type;

   typedef struct packed {
      logic         valid;
      dcs_item_type item;
   } dcs_stage_type;

   typedef struct packed {
      dcs_state_type  new_state;
      dcs_status_type status;
      logic           ack_valid;
      logic [4:0]     ack_code;
   } dcs_result_type;

endpackage

`default_nettype wire

// ----- src/dcs_req_if.sv -----
// ----------------------------------------------------------------------------
// dcs_req_if
// event message channel, valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface dcs_req_if;
   logic       valid;
   logic       ready;
   logic       is_event;
   logic [4:0] op;

   modport source (output valid, output is_event, output op, input ready);
   modport sink   (input valid, input is_event, input op, output ready);
endinterface

`default_nettype wire

// ----- src/dcs_rsp_if.sv -----
// ----------------------------------------------------------------------------
// dcs_rsp_if
// sequencer result channel, valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface dcs_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] new_state;
   logic [1:0] status;
   logic       ack_valid;
   logic [4:0] ack_code;

   modport source (output valid, output new_state, output status, output ack_valid,
                   output ack_code, input ready);
   modport sink   (input valid, input new_state, input status, input ack_valid,
                   input ack_code, output ready);
endinterface

`default_nettype wire

// ----- src/dcs_in_stage.sv -----
// ----------------------------------------------------------------------------
// dcs_in_stage
// input register for event messages
// ----------------------------------------------------------------------------
`default_nettype none

module dcs_in_stage (
   input  wire logic            clock,
   input  wire logic            reset,
   dcs_req_if.sink              req_chan,
   input  wire logic            slot_free,
   output dcs_pkg::dcs_stage_type stage
);
   import dcs_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   dcs_item_type item_ff;
   logic         take;

   // stage empties whenever the result slot can take it
   assign req_chan.ready = !valid_ff || slot_free;
   assign take           = req_chan.valid && req_chan.ready;
   assign valid_in       = take || (valid_ff && !slot_free);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.is_event <= req_chan.is_event;
         item_ff.op       <= req_chan.op;
      end
   end

   assign stage.valid = valid_ff;
   assign stage.item  = item_ff;

endmodule

`default_nettype wire

// ----- src/dcs_decide.sv -----
// ----------------------------------------------------------------------------
// dcs_decide
// next-state table: state and event code to result
// ----------------------------------------------------------------------------
`default_nettype none

module dcs_decide (
   input  wire dcs_pkg::dcs_state_type cur_state,
   input  wire dcs_pkg::dcs_item_type  item,
   output dcs_pkg::dcs_result_type     result
);
   import dcs_pkg::*;

   logic is_ref;

   assign is_ref = (item.op == OP_REF_DEPTH) || (item.op == OP_REF_SHIFT);

   always_comb begin
      result.new_state = cur_state;
      result.status    = STS_OK;
      result.ack_valid = 1'b0;
      result.ack_code  = OP_NONE;
      if (!item.is_event) begin
         result.status = STS_IGNORED;
      end else if (cur_state == ST_IDLE) begin
         case (item.op) inside
            [OP_OPEN:OP_PARA_LAST]: begin
               result.ack_valid = 1'b1;
               result.ack_code  = item.op;
            end
            OP_TRIG_R: result.new_state = ST_TRIG_R;
            OP_TRIG_B: result.new_state = ST_TRIG_B;
            OP_TRIG_P: result.new_state = ST_TRIG_P;
            OP_SYNC:   result.status    = STS_OK;
            default:   result.status    = STS_INVALID;
         endcase
      end else if (item.op == OP_TIMEOUT) begin
         result.new_state = ST_IDLE;
         result.status    = STS_TIMEOUT;
      end else begin
         result.status = STS_INVALID;
         unique case (cur_state)
            ST_IDLE: begin
               result.status = STS_INVALID;
            end
            ST_TRIG_B: begin
               if (item.op == OP_B_IRQ) begin
                  result.new_state = ST_B_DONE;
                  result.status    = STS_OK;
               end
            end
            ST_TRIG_P: begin
               if (item.op == OP_P_IRQ) begin
                  result.new_state = ST_P_DONE;
                  result.status    = STS_OK;
               end else if (is_ref) begin
                  result.new_state = ST_IDLE;
                  result.status    = STS_OK;
               end
            end
            ST_TRIG_R: begin
               if (item.op == OP_R_IRQ) begin
                  result.new_state = ST_IDLE;
                  result.status    = STS_OK;
                  result.ack_valid = 1'b1;
                  result.ack_code  = OP_TRIG_R;
               end
            end
            ST_TRIG_BP: begin
               if (item.op == OP_P_IRQ) begin
                  result.new_state = ST_BP_DONE;
                  result.status    = STS_OK;
               end else if (is_ref) begin
                  result.new_state = ST_IDLE;
                  result.status    = STS_OK;
               end
            end
            ST_B_DONE: begin
               if (item.op == OP_TRIG_BP) begin
                  result.new_state = ST_TRIG_BP;
                  result.status    = STS_OK;
                  result.ack_valid = 1'b1;
                  result.ack_code  = OP_TRIG_B;
               end
            end
            ST_P_DONE: begin
               if (is_ref) begin
                  result.new_state = ST_IDLE;
                  result.status    = STS_OK;
                  result.ack_valid = 1'b1;
                  result.ack_code  = OP_TRIG_P;
               end
            end
            ST_BP_DONE: begin
               if (is_ref) begin
                  result.new_state = ST_IDLE;
                  result.status    = STS_OK;
                  result.ack_valid = 1'b1;
                  result.ack_code  = OP_TRIG_BP;
               end
            end
            default: begin
               result.status = STS_INVALID;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ----- src/dcs_out_stage.sv -----
// ----------------------------------------------------------------------------
// dcs_out_stage
// result register and sequencer state register
// ----------------------------------------------------------------------------
`default_nettype none

module dcs_out_stage (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   load,
   input  wire dcs_pkg::dcs_result_type result,
   dcs_rsp_if.source                   rsp_chan,
   output logic                        slot_free,
   output dcs_pkg::dcs_state_type      cur_state
);
   import dcs_pkg::*;

   logic           valid_ff;
   logic           valid_in;
   dcs_state_type  state_ff;
   dcs_result_type result_ff;

   assign slot_free = !valid_ff || rsp_chan.ready;
   assign valid_in  = load || (valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         state_ff <= ST_IDLE;
      end else begin
         valid_ff <= valid_in;
         if (load) begin
            state_ff  <= result.new_state;
            result_ff <= result;
         end
      end
   end

   assign cur_state          = state_ff;
   assign rsp_chan.valid     = valid_ff;
   assign rsp_chan.new_state = result_ff.new_state;
   assign rsp_chan.status    = result_ff.status;
   assign rsp_chan.ack_valid = result_ff.ack_valid;
   assign rsp_chan.ack_code  = result_ff.ack_code;

endmodule

`default_nettype wire

// ----- src/depth_capture_sequencer_core.sv -----
// ----------------------------------------------------------------------------
// depth_capture_sequencer_core
// eight-state depth capture sequencer, one result per event message
// ----------------------------------------------------------------------------
// channel   dir  payload                                 handshake
// req_chan  in   is_event, op                            valid/ready
// rsp_chan  out  new_state, status, ack_valid, ack_code  valid/ready
//
// one transaction per cycle sustained while rsp_chan is ready
// path: input register, next-state table, result and state register
// synchronous reset clears both stage valids and puts the state to idle
// a stalled rsp holds the result; req keeps flowing until the input stage fills
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module depth_capture_sequencer_core (
   input  wire logic clock,
   input  wire logic reset,
   dcs_req_if.sink   req_chan,
   dcs_rsp_if.source rsp_chan
);
   import dcs_pkg::*;

   dcs_stage_type  stage;
   dcs_state_type  cur_state;
   dcs_result_type result;
   logic           slot_free;
   logic           load;

   assign load = stage.valid && slot_free;

   dcs_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .slot_free (slot_free),
      .stage     (stage)
   );

   dcs_decide u_decide (
      .cur_state (cur_state),
      .item      (stage.item),
      .result    (result)
   );

   dcs_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .result    (result),
      .rsp_chan  (rsp_chan),
      .slot_free (slot_free),
      .cur_state (cur_state)
   );

   // assertions
   `ASSERT_NEXT(a_req_lands, clock, reset, req_chan.valid && req_chan.ready, stage.valid)
   `ASSERT_IMPLIES(a_rsp_state, clock, reset, rsp_chan.valid, rsp_chan.new_state == cur_state)
   `ASSERT_IMPLIES(a_timeout_idle, clock, reset, rsp_chan.valid && rsp_chan.status == STS_TIMEOUT, rsp_chan.new_state == ST_IDLE && !rsp_chan.ack_valid)
   `ASSERT_NEXT(a_load_shows, clock, reset, load, rsp_chan.valid)

endmodule

`default_nettype wire
